// File: src/pse_pkg.sv
// Package for the postfix stack evaluator: sizes, token and status codes,
// controller states and the result record shared by the top level and its parts.
// Depends on nothing.
package pse_pkg;

    // Stack geometry and value width.
    localparam int DEPTH       = 512;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int SP_W        = $clog2(DEPTH + 1);

    // Field widths of the token and of the result.
    localparam int OPERAND_W   = 16;
    localparam int KIND_W      = 2;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;

    // Stream data widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = ((OPERAND_W + OP_W + 7) / 8) * 8;
    localparam int OUT_BITS    = VALUE_WIDTH + SP_W + STATUS_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH = 2'd0,
        K_OP   = 2'd1,
        K_END  = 2'd2,
        K_NONE = 2'd3
    } t_kind;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_FEW     = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_POST
    } t_state;

    // One result item as it travels to the output register.
    typedef struct packed {
        t_value            value;
        logic [SP_W-1:0]   depth;
        t_status           status;
        logic              final_res;
    } t_result;

endpackage

// File: src/pse_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/pse_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pse_pkg for the value width and type.
module pse_divider
    import pse_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_value i_dividend,
    input  t_value i_divisor,
    output logic   o_done,
    output t_value o_quotient
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   r_busy,  n_busy;
    logic [CNT_W-1:0]       r_cnt,   n_cnt;
    logic [VALUE_WIDTH-1:0] r_rem,   n_rem;
    logic [VALUE_WIDTH-1:0] r_quo,   n_quo;
    logic [VALUE_WIDTH-1:0] r_dsr,   n_dsr;
    logic                   r_neg,   n_neg;
    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   trial;
    logic                   last_step;

    assign last_step = (r_cnt == CNT_W'(VALUE_WIDTH));
    assign shifted   = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign trial     = shifted - {1'b0, r_dsr};

    // Load magnitudes on start, then one restoring step per cycle.
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend[VALUE_WIDTH-1] ? -i_dividend : i_dividend;
            n_dsr  = i_divisor[VALUE_WIDTH-1] ? -i_divisor : i_divisor;
            n_neg  = i_dividend[VALUE_WIDTH-1] ^ i_divisor[VALUE_WIDTH-1];
        end else if (r_busy) begin
            if (last_step) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
                if (!trial[VALUE_WIDTH]) begin
                    n_rem = trial[VALUE_WIDTH-1:0];
                    n_quo = {r_quo[VALUE_WIDTH-2:0], 1'b1};
                end else begin
                    n_rem = shifted[VALUE_WIDTH-1:0];
                    n_quo = {r_quo[VALUE_WIDTH-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
        r_neg <= n_neg;
    end

    // The quotient magnitude gets its sign in the cycle it is reported.
    assign o_done     = r_busy && last_step;
    assign o_quotient = r_neg ? t_value'(-r_quo) : t_value'(r_quo);

endmodule

// File: src/postfix_stack_evaluator.sv
// Postfix token evaluator: the value stack lives in a RAM, the top entry is also
// kept in a register. Depends on pse_pkg, pse_ram and pse_divider.
//
//  channel | direction | tdata (low bits up)               | tuser
//  --------+-----------+------------------------------------+-----------
//  s       | in        | operand[15:0], op_code[17:16]      | kind
//  m       | out       | top_value, stack_depth, status     | final_res
//
// A push, an ignored token, an end on one entry, and any error finish in the
// cycle the item is accepted. Add, subtract, multiply and an end on a deeper
// stack first read the entry below the top from the RAM, then do the update.
// A divide reads that entry, then waits on the bit-serial divider (one bit per cycle).
// Reset is synchronous and active low; it empties the stack, RAM contents stay.
// A result that finds the output register still full waits in a holding
// register, and no new item is accepted until it has moved on.
module postfix_stack_evaluator
    import pse_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // operand, op_code
    input  logic [KIND_W-1:0]      i_s_tuser,   // kind
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // top_value, stack_depth, status
    output logic                   o_m_tuser    // final_res
);

    t_state          r_state, n_state;
    logic [SP_W-1:0] r_sp,    n_sp;
    t_value          r_top,   n_top;
    logic            r_is_end, n_is_end;
    t_op             r_op,    n_op;
    t_result         r_res,   n_res;
    t_result         r_out,   n_out;
    logic            r_out_valid, n_out_valid;

    logic            accept;
    logic            out_free;
    logic            fin;
    t_result         res;
    t_kind           in_kind;
    t_op             in_op;
    t_value          in_value;
    t_value          top_or_zero;
    logic [SP_W-1:0] sp_minus1;
    logic [SP_W-1:0] sp_minus2;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_value            wr_data;
    logic              rd_en;
    t_value            rd_data;
    t_value            alu_out;

    logic   div_start;
    logic   div_done;
    t_value div_quo;

    assign in_kind     = t_kind'(i_s_tuser);
    assign in_op       = t_op'(i_s_tdata[OPERAND_W+OP_W-1:OPERAND_W]);
    assign in_value    = t_value'(i_s_tdata[OPERAND_W-1:0]);
    assign top_or_zero = (r_sp == '0) ? t_value'(0) : r_top;
    assign sp_minus1   = r_sp - SP_W'(1);
    assign sp_minus2   = r_sp - SP_W'(2);
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign accept      = i_s_tvalid && o_s_tready;

    // Stack storage.
    pse_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (sp_minus2[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Signed divider for the divide operator.
    pse_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (rd_data),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Add, subtract and multiply on the entry below the top and the top.
    always_comb begin
        case (r_op)
            OP_ADD:  alu_out = rd_data + r_top;
            OP_SUB:  alu_out = rd_data - r_top;
            default: alu_out = rd_data * r_top;
        endcase
    end

    // Controller: next state, stack updates and the result of each item.
    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_top       = r_top;
        n_is_end    = r_is_end;
        n_op        = r_op;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;
        fin         = 1'b0;
        res         = '{value: top_or_zero, depth: r_sp, status: ST_OK, final_res: 1'b0};
        wr_en       = 1'b0;
        wr_addr     = sp_minus2[ADDR_W-1:0];
        wr_data     = alu_out;
        rd_en       = 1'b0;
        div_start   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (in_kind)
                        K_PUSH: begin
                            fin = 1'b1;
                            if (r_sp == SP_W'(DEPTH)) begin
                                res.status = ST_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = r_sp[ADDR_W-1:0];
                                wr_data   = in_value;
                                n_top     = in_value;
                                n_sp      = r_sp + SP_W'(1);
                                res.value = in_value;
                                res.depth = r_sp + SP_W'(1);
                            end
                        end
                        K_OP: begin
                            if (r_sp < SP_W'(2)) begin
                                fin        = 1'b1;
                                res.status = ST_FEW;
                            end else if (in_op == OP_DIV && r_top == '0) begin
                                fin        = 1'b1;
                                res.status = ST_DIVZERO;
                            end else begin
                                rd_en    = 1'b1;
                                n_is_end = 1'b0;
                                n_op     = in_op;
                                n_state  = S_EXEC;
                            end
                        end
                        K_END: begin
                            if (r_sp == '0) begin
                                fin        = 1'b1;
                                res.status = ST_EMPTY;
                            end else if (r_sp == SP_W'(1)) begin
                                // Last entry: the stack becomes empty.
                                fin           = 1'b1;
                                n_sp          = '0;
                                n_top         = '0;
                                res.value     = r_top;
                                res.depth     = '0;
                                res.final_res = 1'b1;
                            end else begin
                                rd_en    = 1'b1;
                                n_is_end = 1'b1;
                                n_state  = S_EXEC;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (r_is_end) begin
                    // The entry below becomes the new top.
                    fin           = 1'b1;
                    n_top         = rd_data;
                    n_sp          = sp_minus1;
                    res.value     = r_top;
                    res.depth     = sp_minus1;
                    res.final_res = 1'b1;
                end else if (r_op == OP_DIV) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    fin       = 1'b1;
                    wr_en     = 1'b1;
                    n_top     = alu_out;
                    n_sp      = sp_minus1;
                    res.value = alu_out;
                    res.depth = sp_minus1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    fin       = 1'b1;
                    wr_en     = 1'b1;
                    wr_data   = div_quo;
                    n_top     = div_quo;
                    n_sp      = sp_minus1;
                    res.value = div_quo;
                    res.depth = sp_minus1;
                end
            end
            S_POST: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished result goes to the output register or waits for it.
        if (fin) begin
            if (out_free) begin
                n_out       = res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_res   = res;
                n_state = S_POST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
        r_top    <= n_top;
        r_is_end <= n_is_end;
        r_op     <= n_op;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    // Output item.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_out.status, r_out.depth, r_out.value});
    assign o_m_tuser  = r_out.final_res;

    // The stack pointer never passes the stack depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(DEPTH))
        else $error("stack pointer beyond depth");

    // A divider start is always followed by the wait for its quotient.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == S_DIV))
        else $error("divider started outside the divide sequence");

    // A held result only exists while the output register is occupied.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST) |-> r_out_valid)
        else $error("result held with an empty output register");

    // A final value is only reported with an ok status.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (r_out.status == ST_OK))
        else $error("final value reported with an error status");

endmodule
